// File: hdl/nearest_palette_colour_search_core_defines.svh
`ifndef NEAREST_PALETTE_COLOUR_SEARCH_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOUR_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define NPCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/npcs_pkg.sv
`timescale 1ns / 1ps

package npcs_pkg;

   localparam int LEVEL_BITS  = 5;
   localparam int LEVEL_COUNT = 2 ** LEVEL_BITS;
   localparam int LEVEL_MAX   = LEVEL_COUNT - 1;
   localparam int INDEX_W     = 8;
   localparam int DIST_W      = 18;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [INDEX_W-1:0]    entry_index;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [LEVEL_BITS-1:0] query_red;
      logic [LEVEL_BITS-1:0] query_green;
      logic [LEVEL_BITS-1:0] query_blue;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  best_distance;
   } rsp_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   // control that travels with the entry leaving the head of the ring
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic [INDEX_W-1:0] index;
   } scan_ctrl_type;

   typedef logic [LEVEL_COUNT-1:0][7:0] expand_lut_type;

   // level -> 8 bits, c*255/LEVEL_MAX rounded half up
   function automatic expand_lut_type build_expand_lut();
      expand_lut_type lut;
      for (int c = 0; c < LEVEL_COUNT; c++) begin
         lut[c] = 8'((c * 255 + (LEVEL_MAX - 1) / 2) / LEVEL_MAX);
      end
      return lut;
   endfunction

   localparam expand_lut_type EXPAND_LUT = build_expand_lut();

endpackage

// File: hdl/npcs_cell.sv
`timescale 1ns / 1ps

module npcs_cell
   import npcs_pkg::*;
(
   input  logic    clock,
   input  logic    load_en,
   input  rgb_type load_data,
   input  logic    shift_en,
   input  rgb_type neighbor_data,
   output rgb_type data
);

   rgb_type data_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         data_ff <= load_data;
      end else if (shift_en) begin
         data_ff <= neighbor_data;
      end
   end

   assign data = data_ff;

endmodule

// File: hdl/npcs_dist.sv
`timescale 1ns / 1ps

module npcs_dist
   import npcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  rgb_type            query,
   input  rgb_type            entry,
   input  scan_ctrl_type      ctrl,
   output logic               done,
   output logic [INDEX_W-1:0] best_index,
   output logic [DIST_W-1:0]  best_distance
);

   logic [7:0]         diff_r, diff_g, diff_b;
   logic [15:0]        sq_r_ff, sq_g_ff, sq_b_ff;
   scan_ctrl_type      ctrl_ff;
   logic [DIST_W-1:0]  sum;
   logic [DIST_W-1:0]  best_sq_ff;
   logic [INDEX_W-1:0] best_idx_ff;
   logic               done_ff;

   assign diff_r = (entry.r > query.r) ? entry.r - query.r : query.r - entry.r;
   assign diff_g = (entry.g > query.g) ? entry.g - query.g : query.g - entry.g;
   assign diff_b = (entry.b > query.b) ? entry.b - query.b : query.b - entry.b;

   // stage 1: squares
   always_ff @(posedge clock) begin
      sq_r_ff <= diff_r * diff_r;
      sq_g_ff <= diff_g * diff_g;
      sq_b_ff <= diff_b * diff_b;
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl;
      end
   end

   assign sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   // stage 2: running minimum, strict less keeps the first on ties
   always_ff @(posedge clock) begin
      if (ctrl_ff.valid && (ctrl_ff.first || sum < best_sq_ff)) begin
         best_sq_ff  <= sum;
         best_idx_ff <= ctrl_ff.index;
      end
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= ctrl_ff.valid && ctrl_ff.last;
      end
   end

   assign done          = done_ff;
   assign best_index    = best_idx_ff;
   assign best_distance = best_sq_ff;

endmodule

// File: hdl/nearest_palette_colour_search_core.sv
`timescale 1ns / 1ps

// Nearest palette colour search. The palette sits in a ring of PALETTE_SIZE
// cells, one RGB entry per cell. A write item loads one cell and gives no
// result; writes to indexes at or beyond PALETTE_SIZE are dropped. A query
// item expands its levels to 8 bits, then the ring rotates one cell per
// cycle past a single two-stage distance unit until it has turned once, so
// every entry but entry 0 is checked and the ring ends back at home.
// req_stall stays high from the query through the scan and drain until the
// result enters the output register, also while an earlier result still
// blocks that register. Ties go to the lowest index. A query reads entries
// 1 to PALETTE_SIZE-1, so all of them must be written first. No clearing
// pass follows reset.
module nearest_palette_colour_search_core
   import npcs_pkg::*;
#(
   parameter int PALETTE_SIZE = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam int STEP_W = $clog2(PALETTE_SIZE);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      SEND
   } state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  step_ff;
   rgb_type            query_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_item_ff;

   logic               req_accept;
   logic               rsp_free;
   logic               step_last;
   rgb_type            ring [PALETTE_SIZE];
   scan_ctrl_type      scan_ctrl;
   logic               dist_done;
   logic [INDEX_W-1:0] dist_index;
   logic [DIST_W-1:0]  dist_value;
   rgb_type            write_data;

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign step_last  = (step_ff == STEP_W'(PALETTE_SIZE - 1));

   assign write_data.r = req_item.red;
   assign write_data.g = req_item.green;
   assign write_data.b = req_item.blue;

   for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_ring
      npcs_cell u_cell (
         .clock         (clock),
         .load_en       (req_accept && req_item.cmd == CMD_WRITE &&
                         req_item.entry_index == INDEX_W'(i)),
         .load_data     (write_data),
         .shift_en      (state_ff == SCAN),
         .neighbor_data (ring[(i + 1) % PALETTE_SIZE]),
         .data          (ring[i])
      );
   end

   // cell 0 holds entry step_ff during the scan
   always_comb begin
      scan_ctrl.valid = (state_ff == SCAN) && (step_ff != '0);
      scan_ctrl.first = (step_ff == STEP_W'(1));
      scan_ctrl.last  = step_last;
      scan_ctrl.index = INDEX_W'(step_ff);
   end

   npcs_dist u_dist (
      .clock         (clock),
      .reset         (reset),
      .query         (query_ff),
      .entry         (ring[0]),
      .ctrl          (scan_ctrl),
      .done          (dist_done),
      .best_index    (dist_index),
      .best_distance (dist_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // SEND handles its own hand-off of the output register
         if (rsp_valid_ff && !rsp_stall && state_ff != SEND) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_accept && req_item.cmd == CMD_QUERY) begin
                  query_ff.r <= EXPAND_LUT[req_item.query_red];
                  query_ff.g <= EXPAND_LUT[req_item.query_green];
                  query_ff.b <= EXPAND_LUT[req_item.query_blue];
                  step_ff    <= '0;
                  state_ff   <= SCAN;
               end
            end
            SCAN: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_last) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (dist_done) begin
                  state_ff <= SEND;
               end
            end
            SEND: begin
               if (rsp_free) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_item_ff.best_index    <= dist_index;
                  rsp_item_ff.best_distance <= dist_value;
                  state_ff                  <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: hdl/npcs_checker.sv
`timescale 1ns / 1ps

`include "nearest_palette_colour_search_core_defines.svh"

module npcs_checker
   import npcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   logic query_taken;
   logic write_taken;

   assign query_taken = req_valid && !req_stall && req_item.cmd == CMD_QUERY;
   assign write_taken = req_valid && !req_stall && req_item.cmd == CMD_WRITE;

   `NPCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_item), "stalled result item changed or dropped")

   `NPCS_ASSERT_NEXT(a_query_busy, clock, reset, query_taken, req_stall,
      "block took another item right after a query")

   `NPCS_ASSERT_NEXT(a_write_silent, clock, reset, write_taken, !$rose(rsp_valid),
      "write item produced a result")

   `NPCS_ASSERT_NOW(a_index_nonzero, clock, reset, rsp_valid, rsp_item.best_index != '0,
      "transparent entry returned as nearest")

endmodule

bind nearest_palette_colour_search_core npcs_checker u_npcs_checker (.*);

// File: tb/nearest_palette_colour_search_core_tb.sv
`timescale 1ns / 1ps

module nearest_palette_colour_search_core_tb
   import npcs_pkg::*;
();

   localparam int PALETTE_SIZE = 256;
   localparam int RANDOM_ITEMS = 270;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = PALETTE_SIZE + 16;
   localparam int REQ_W        = $bits(req_type);
   localparam int RGB_W        = $bits(rgb_type);

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   req_type pending_items[$];
   rsp_type expected_colours[$];

   rgb_type plan_palette[PALETTE_SIZE];    // palette as the stimulus plan leaves it
   rgb_type shadow_palette[PALETTE_SIZE];  // palette as accepted by the block

   int items_total      = 0;
   int items_accepted   = 0;
   int writes_accepted  = 0;
   int queries_accepted = 0;
   int results_checked  = 0;
   int fail_count       = 0;
   int cycle_count      = 0;

   int burst_left = 1;
   int gap_left   = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int mode_left  = 0;
   int hold_left  = 0;

   nearest_palette_colour_search_core #(
      .PALETTE_SIZE(PALETTE_SIZE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int level_to_byte(input int level);
      return (level * 255 + (LEVEL_MAX - 1) / 2) / LEVEL_MAX;
   endfunction

   function automatic rgb_type grid_colour(input int lr, input int lg, input int lb);
      rgb_type c;
      c.r = 8'(level_to_byte(lr));
      c.g = 8'(level_to_byte(lg));
      c.b = 8'(level_to_byte(lb));
      return c;
   endfunction

   // linear scan over entries 1..N-1, strict less-than keeps the first minimum
   function automatic rsp_type nearest_entry(input req_type q);
      int qr, qg, qb, dr, dg, db, sq_sum, best_sq, best_idx;
      rsp_type res;
      qr = level_to_byte(int'(q.query_red));
      qg = level_to_byte(int'(q.query_green));
      qb = level_to_byte(int'(q.query_blue));
      best_sq  = 32'h100_0000;
      best_idx = 0;
      for (int i = 1; i < PALETTE_SIZE; i++) begin
         dr     = int'(shadow_palette[i].r) - qr;
         dg     = int'(shadow_palette[i].g) - qg;
         db     = int'(shadow_palette[i].b) - qb;
         sq_sum = dr * dr + dg * dg + db * db;
         if (sq_sum < best_sq) begin
            best_sq  = sq_sum;
            best_idx = i;
         end
      end
      res.best_index    = INDEX_W'(best_idx);
      res.best_distance = DIST_W'(best_sq);
      return res;
   endfunction

   task automatic push_write(input int idx, input rgb_type c);
      req_type it;
      it             = req_type'(REQ_W'({$urandom, $urandom}));
      it.cmd         = CMD_WRITE;
      it.entry_index = INDEX_W'(idx);
      it.red         = c.r;
      it.green       = c.g;
      it.blue        = c.b;
      if (idx < PALETTE_SIZE) plan_palette[idx] = c;
      pending_items.push_back(it);
      items_total++;
   endtask

   task automatic push_query(input int lr, input int lg, input int lb);
      req_type it;
      it             = req_type'(REQ_W'({$urandom, $urandom}));
      it.cmd         = CMD_QUERY;
      it.query_red   = LEVEL_BITS'(lr);
      it.query_green = LEVEL_BITS'(lg);
      it.query_blue  = LEVEL_BITS'(lb);
      pending_items.push_back(it);
      items_total++;
   endtask

   task automatic apply_item(input req_type it);
      if (it.cmd == CMD_WRITE) begin
         if (int'(it.entry_index) < PALETTE_SIZE) begin
            shadow_palette[it.entry_index] = '{r: it.red, g: it.green, b: it.blue};
         end
         writes_accepted++;
      end else begin
         expected_colours.push_back(nearest_entry(it));
         queries_accepted++;
      end
   endtask

   // sender: bursts of random length, random gaps, payload held while stalled
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_item(req_item);
            items_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_item  <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern: a randomly chosen mode (none, random, long holds) for a random span
   always @(posedge clock) begin : rsp_staller
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 600);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               if (hold_left > 0) begin
                  hold_left--;
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
                  if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 40);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colours.size() == 0) begin
            $display("%0t: unexpected item: actual index %0d distance %0d",
                     $time, rsp_item.best_index, rsp_item.best_distance);
            fail_count++;
         end else begin
            want = expected_colours.pop_front();
            results_checked++;
            if (rsp_item.best_index !== want.best_index) begin
               $display("%0t: best_index mismatch: expected %0d actual %0d",
                        $time, want.best_index, rsp_item.best_index);
               fail_count++;
            end
            if (rsp_item.best_distance !== want.best_distance) begin
               $display("%0t: best_distance mismatch: expected %0d actual %0d",
                        $time, want.best_distance, rsp_item.best_distance);
               fail_count++;
            end
         end
      end
   end

   initial begin : timeout_watch
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("nearest_palette_colour_search_core test failed");
      $finish;
   end

   initial begin : stimulus
      rgb_type c;
      int lr, lg, lb;
      int src;

      // flat white palette: worst distance from black, ties on every entry
      for (int i = 0; i < PALETTE_SIZE; i++) push_write(i, '{r: 8'hff, g: 8'hff, b: 8'hff});
      push_query(0, 0, 0);
      push_query(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);

      // black and white at the ends
      push_write(1, '{r: 8'h00, g: 8'h00, b: 8'h00});
      push_write(PALETTE_SIZE - 1, '{r: 8'hff, g: 8'hff, b: 8'hff});

      push_query(0, 0, 0);
      push_query(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
      push_query(LEVEL_MAX, 0, 0);
      push_query(0, LEVEL_MAX, 0);
      push_query(0, 0, LEVEL_MAX);
      push_query(LEVEL_MAX, LEVEL_MAX, 0);
      // entry 0 holds an exact match but must be skipped
      push_write(0, grid_colour(12, 3, 29));
      push_query(12, 3, 29);
      // exact match in two entries: lower index wins
      push_write(200, grid_colour(20, 9, 4));
      push_write(77, grid_colour(20, 9, 4));
      push_query(20, 9, 4);
      // exact match on the last entry
      push_write(PALETTE_SIZE - 1, grid_colour(1, 30, 16));
      push_query(1, 30, 16);
      push_query(16, 15, 1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         lr = $urandom_range(0, LEVEL_MAX);
         lg = $urandom_range(0, LEVEL_MAX);
         lb = $urandom_range(0, LEVEL_MAX);
         if ($urandom_range(0, 4) < 2) begin
            push_query(lr, lg, lb);
         end else begin
            case ($urandom_range(0, 2))
               0: c = grid_colour(lr, lg, lb);
               1: begin
                  src = $urandom_range(0, PALETTE_SIZE - 1);
                  c   = plan_palette[src];
               end
               default: c = rgb_type'(RGB_W'($urandom));
            endcase
            push_write($urandom_range(0, PALETTE_SIZE - 1), c);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (items_accepted == items_total && results_checked == queries_accepted);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d palette writes and %0d nearest-colour queries, %0d results checked",
               writes_accepted, queries_accepted, results_checked);
      $display("mismatches: %0d, results still owed: %0d", fail_count, expected_colours.size());
      if (fail_count == 0 && expected_colours.size() == 0) begin
         $display("nearest_palette_colour_search_core test passed");
      end else begin
         $display("nearest_palette_colour_search_core test failed");
      end
      $finish;
   end

endmodule
